// File: rtl/core/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths and reset values for the moving average block.
// ----------------------------------------------------------------------------
package swa_pkg;

   // result field widths, fixed by the output word layout
   localparam int AVG_BITS = 24;
   localparam int CNT_BITS = 9;
   // window size register width and its reset value
   localparam int CFG_BITS = 9;
   localparam int WIN_RESET = 1;
   // fraction bits of the average
   localparam int FRAC_BITS = 8;
   // output word: average then count, padded to whole bytes
   localparam int RSP_BITS = ((AVG_BITS + CNT_BITS + 7) / 8) * 8;

endpackage

// File: rtl/core/swa_ring.sv
// ----------------------------------------------------------------------------
// swa_ring
// Sample ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swa_ring #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div
// Unsigned restoring divider, one quotient bit per cycle over the dividend.
// ----------------------------------------------------------------------------
module swa_div #(
   parameter int DW = 33,
   parameter int VW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [VW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VW:0]      shifted;
   logic [VW+1:0]    trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial remainder only when it did not go negative
         if (trial[VW+1]) begin
            rem_in = shifted[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average of signed samples over the last window_size words.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata: sample
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: average_q8, samples_in_window
// csr      in   csr_valid/csr_ready    csr_data: window_size
//
// After a word is taken, the ring read rides on the accept edge. Then come
// the sum update and ring write in ST_UPDATE, the restoring divider in ST_DIV
// (one bit of the scaled sum per cycle) and the load of the output register
// in ST_DONE once rsp has room. The next word is taken only after that load,
// back in ST_IDLE. The next word is taken while a result waits in rsp.
// A second result waits in the core and stalls req.
// Reset is synchronous; the ring needs no clearing pass, so words are taken
// right after reset. A write to window_size clears sum, count and pointer.
// ----------------------------------------------------------------------------
module sliding_window_average #(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: sample
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: average_q8 [23:0], samples_in_window [32:24]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [swa_pkg::RSP_BITS-1:0]          rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swa_pkg::CFG_BITS-1:0]          csr_data
);

   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int SUM_W = SAMPLE_BITS + AW + 1;
   localparam int DW    = SUM_W + swa_pkg::FRAC_BITS;
   localparam int MAG_W = SAMPLE_BITS + swa_pkg::FRAC_BITS;
   localparam int RES_W = MAG_W + 1;
   localparam int EXT_W = (RES_W > swa_pkg::AVG_BITS) ? RES_W : swa_pkg::AVG_BITS;
   localparam int CMP_W = (CW > swa_pkg::CFG_BITS) ? CW : swa_pkg::CFG_BITS;
   localparam int CNX_W = (CW > swa_pkg::CNT_BITS) ? CW : swa_pkg::CNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             window_ff, window_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [swa_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [AW-1:0]             slot;
   logic [CW-1:0]             slot_next;
   logic                      full;
   logic [SAMPLE_BITS-1:0]    ring_rd;
   logic                      ring_we;
   logic                      div_start;
   logic                      div_done;
   logic [DW-1:0]             div_dividend;
   logic [DW-1:0]             quotient;
   logic [SUM_W-1:0]          sum_abs;
   logic [CMP_W-1:0]          cfg_wide;
   logic [CW-1:0]             cfg_clamped;
   logic signed [RES_W-1:0]   avg_res;
   logic signed [EXT_W-1:0]   avg_ext;
   logic [CNX_W-1:0]          cnt_ext;
   logic                      accept;
   logic                      slot_free;

   swa_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (slot),
      .wr_data (sample_ff),
      .rd_addr (slot),
      .rd_data (ring_rd)
   );

   swa_div #(
      .DW (DW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // pointer always stays below the window; guard anyway
   assign slot      = ({1'b0, ptr_ff} >= (AW+1)'(window_ff)) ? '0 : ptr_ff;
   assign slot_next = CW'(slot) + 1'b1;
   assign full      = (fill_ff >= window_ff);

   // clamp the written size into 1..MAX_WINDOW
   always_comb begin
      cfg_wide = CMP_W'(csr_data);
      if (cfg_wide == '0) begin
         cfg_clamped = CW'(1);
      end else if (cfg_wide > CMP_W'(MAX_WINDOW)) begin
         cfg_clamped = CW'(MAX_WINDOW);
      end else begin
         cfg_clamped = cfg_wide[CW-1:0];
      end
   end

   assign sum_abs      = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
   assign div_dividend = {sum_abs, {swa_pkg::FRAC_BITS{1'b0}}};
   assign ring_we      = (state_ff == ST_UPDATE);
   assign div_start    = (state_ff == ST_UPDATE);

   always_comb begin
      avg_res = neg_ff ? -$signed({1'b0, quotient[MAG_W-1:0]})
                       :  $signed({1'b0, quotient[MAG_W-1:0]});
      avg_ext = EXT_W'(avg_res);
      cnt_ext = CNX_W'(fill_ff);
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // drop the oldest word once the window is full
            if (full) begin
               sum_in  = sum_ff - SUM_W'($signed(ring_rd))
                                + SUM_W'($signed(sample_ff));
               fill_in = window_ff;
            end else begin
               sum_in  = sum_ff + SUM_W'($signed(sample_ff));
               fill_in = fill_ff + 1'b1;
            end
            ptr_in   = (slot_next >= window_ff) ? '0 : slot_next[AW-1:0];
            neg_in   = sum_in[SUM_W-1];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = swa_pkg::RSP_BITS'({cnt_ext[swa_pkg::CNT_BITS-1:0],
                                                  avg_ext[swa_pkg::AVG_BITS-1:0]});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         window_in = cfg_clamped;
         fill_in   = '0;
         ptr_in    = '0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= CW'(swa_pkg::WIN_RESET);
         fill_ff      <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/sliding_window_average_test.sv
// ----------------------------------------------------------------------------
// sliding_window_average_test
// Self-checking bench for the moving average block. A table of directed
// words runs first, then random phases with a new window size each. Every
// accepted sample is run through a local copy of the window and sum. Each
// result word is compared against the expectation queue built from it.
// ----------------------------------------------------------------------------
module sliding_window_average_test;

   localparam int MAX_WINDOW   = 256;
   localparam int REQ_BITS     = 16;
   localparam int SAMPLE_GOAL  = 1100;
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef enum logic {ROW_WINDOW, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      logic [swa_pkg::AVG_BITS-1:0] average_q8;
      logic [swa_pkg::CNT_BITS-1:0] samples_in_window;
   } avg_word_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic [15:0]                  value;
      logic                         typed;
      logic [swa_pkg::AVG_BITS-1:0] exp_avg;
      logic [swa_pkg::CNT_BITS-1:0] exp_cnt;
   } dir_row_type;

   // window size is 1 after reset
   localparam int NUM_ROWS = 25;
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_SAMPLE, 16'h7FFF, 1'b1, 24'h7FFF00, 9'd1},
      '{ROW_SAMPLE, 16'h8000, 1'b1, 24'h800000, 9'd1},
      '{ROW_SAMPLE, 16'h0000, 1'b1, 24'h000000, 9'd1},
      '{ROW_SAMPLE, 16'hFFFF, 1'b1, 24'hFFFF00, 9'd1},
      '{ROW_WINDOW, 16'd0,    1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'h0005, 1'b1, 24'h000500, 9'd1},
      '{ROW_SAMPLE, 16'h5A5A, 1'b1, 24'h5A5A00, 9'd1},
      '{ROW_WINDOW, 16'd2,    1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'hFFFF, 1'b1, 24'hFFFF00, 9'd1},
      '{ROW_SAMPLE, 16'h0000, 1'b1, 24'hFFFF80, 9'd2},
      '{ROW_SAMPLE, 16'h0001, 1'b1, 24'h000080, 9'd2},
      '{ROW_WINDOW, 16'd3,    1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'h0001, 1'b1, 24'h000100, 9'd1},
      '{ROW_SAMPLE, 16'h0001, 1'b1, 24'h000100, 9'd2},
      '{ROW_SAMPLE, 16'h0000, 1'b1, 24'h0000AA, 9'd3},
      '{ROW_SAMPLE, 16'h8000, 1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'h8000, 1'b0, 24'h0,      9'd0},
      '{ROW_WINDOW, 16'h01FF, 1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'h7FFF, 1'b1, 24'h7FFF00, 9'd1},
      '{ROW_SAMPLE, 16'hA5A5, 1'b0, 24'h0,      9'd0},
      '{ROW_WINDOW, 16'd256,  1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'h8000, 1'b1, 24'h800000, 9'd1},
      '{ROW_SAMPLE, 16'h0001, 1'b0, 24'h0,      9'd0},
      '{ROW_WINDOW, 16'd257,  1'b0, 24'h0,      9'd0},
      '{ROW_SAMPLE, 16'h1234, 1'b0, 24'h0,      9'd0}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_BITS-1:0]          req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [swa_pkg::RSP_BITS-1:0] rsp_tdata;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [swa_pkg::CFG_BITS-1:0] csr_data = '0;

   // local copy of the window
   logic signed [15:0] sample_history [MAX_WINDOW];
   int unsigned        win_len = swa_pkg::WIN_RESET;
   int unsigned        window_fill = 0;
   int unsigned        ring_ptr = 0;
   longint             window_sum = 0;

   avg_word_type pending_averages [$];
   int unsigned  mismatches = 0;
   int unsigned  samples_sent = 0;
   bit           hold_rsp_req = 1'b0;

   sliding_window_average DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic avg_word_type predict_average(input logic signed [15:0] s);
      avg_word_type res;
      longint       scaled;
      if (ring_ptr >= win_len) ring_ptr = 0;
      if (window_fill >= win_len) begin
         // full: the oldest sample sits where the new one goes
         window_sum = window_sum - longint'(sample_history[ring_ptr]) + longint'(s);
         window_fill = win_len;
      end else begin
         window_sum = window_sum + longint'(s);
         window_fill++;
      end
      sample_history[ring_ptr] = s;
      ring_ptr = (ring_ptr + 1 >= win_len) ? 0 : ring_ptr + 1;
      scaled = (window_sum * 256) / longint'(window_fill);
      res.average_q8 = scaled[swa_pkg::AVG_BITS-1:0];
      res.samples_in_window = window_fill[swa_pkg::CNT_BITS-1:0];
      return res;
   endfunction

   function automatic logic [15:0] pick_sample(input int unsigned bias);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (bias == 1 && r != 0) return 16'h7FFF;
      if (bias == 2 && r != 0) return 16'h8000;
      case (r)
         6: return 16'h7FFF;
         7: return 16'h8000;
         8: return 16'($urandom_range(0, 6)) - 16'd3;
         9: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // hold valid low for the given number of cycles
   task automatic sender_gap(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic send_sample(input logic [15:0] s, input logic typed,
                              input avg_word_type typed_word);
      avg_word_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      predicted = predict_average(s);
      pending_averages.insert(pending_averages.size(), typed ? typed_word : predicted);
   endtask

   task automatic wait_drained();
      while (pending_averages.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [swa_pkg::CFG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      win_len = (value == 0) ? 1 : (value > MAX_WINDOW) ? MAX_WINDOW : value;
      window_fill = 0;
      ring_ptr = 0;
      window_sum = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall patterns, plus one long hold on request
   initial begin : rsp_stall_pattern
      int unsigned mode;
      int unsigned span;
      int unsigned hold_left;
      int unsigned tick;
      mode = 0;
      span = 0;
      hold_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 200);
            end
            span--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 7) == 0);
               default: rsp_tready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      avg_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_averages.size() == 0) begin
            flag_mismatch($sformatf("unexpected word avg=%h count=%0d",
               rsp_tdata[swa_pkg::AVG_BITS-1:0],
               rsp_tdata[swa_pkg::AVG_BITS +: swa_pkg::CNT_BITS]));
         end else begin
            want = pending_averages[0];
            pending_averages.delete(0);
            if (rsp_tdata[swa_pkg::AVG_BITS-1:0] !== want.average_q8) begin
               flag_mismatch($sformatf("average_q8 got %h want %h",
                  rsp_tdata[swa_pkg::AVG_BITS-1:0], want.average_q8));
            end
            if (rsp_tdata[swa_pkg::AVG_BITS +: swa_pkg::CNT_BITS] !==
                want.samples_in_window) begin
               flag_mismatch($sformatf("samples_in_window got %0d want %0d",
                  rsp_tdata[swa_pkg::AVG_BITS +: swa_pkg::CNT_BITS],
                  want.samples_in_window));
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_averages.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned win_value;
      int unsigned bias;
      int unsigned count;
      int unsigned pick;
      int unsigned burst_left;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_WINDOW) begin
            sender_gap(1);
            wait_drained();
            write_window(DIRECTED[i].value[swa_pkg::CFG_BITS-1:0]);
         end else begin
            send_sample(DIRECTED[i].value, DIRECTED[i].typed,
                        avg_word_type'({DIRECTED[i].exp_avg, DIRECTED[i].exp_cnt}));
            samples_sent++;
         end
      end

      phase = 0;
      while (samples_sent < SAMPLE_GOAL) begin
         case (phase)
            0: begin
               win_value = 4;
               bias = 0;
               count = 40;
            end
            // full window of one extreme, wrapped past the ring end
            1: begin
               win_value = MAX_WINDOW;
               bias = 1;
               count = 280;
            end
            2: begin
               win_value = MAX_WINDOW;
               bias = 2;
               count = 280;
            end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick <= 5) win_value = $urandom_range(1, 8);
               else if (pick == 6) win_value = $urandom_range(9, 40);
               else if (pick == 7) win_value = 0;
               else if (pick == 8) win_value = $urandom_range(257, 511);
               else win_value = $urandom_range(0, 511);
               bias = 0;
               count = $urandom_range(10, 60);
            end
         endcase
         sender_gap(1);
         wait_drained();
         write_window(win_value[swa_pkg::CFG_BITS-1:0]);
         // back up the block behind a stalled receiver
         if (phase == 0) hold_rsp_req = 1'b1;
         burst_left = 0;
         repeat (count) begin
            if (phase != 0) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 40));
               end
               burst_left--;
               if ($urandom_range(0, 199) == 0) begin
                  sender_gap(1);
                  wait_drained();
               end
            end
            send_sample(pick_sample(bias), 1'b0, '0);
            samples_sent++;
         end
         phase++;
      end

      sender_gap(1);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_averages.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sliding_window_average.f
rtl/core/swa_pkg.sv
rtl/core/swa_ring.sv
rtl/core/swa_div.sv
rtl/core/sliding_window_average.sv
tb/sliding_window_average_test.sv
